FILE: rtl/point_in_polygon_crossing_top_assert.svh
// assertion macros for the point-in-polygon block
`ifndef POINT_IN_POLYGON_CROSSING_TOP_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_TOP_ASSERT_SVH

// implication checked outside reset
`define PIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must hold in the cycle after reset is applied
`define PIP_ASSERT_AFTER_RESET(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cond)) \
        else $error(msg);

`endif

FILE: rtl/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

    // default signed coordinate width
    localparam int unsigned CoordBitsDef = 16;

    // result word: inside flag in bit 0, padded to one byte
    localparam int unsigned OutTdataW = 8;

endpackage

FILE: rtl/point_in_polygon_crossing_top.sv
`timescale 1ns / 1ps

// Crossing-number point-in-polygon test. One vertex word is taken per cycle
// with no gaps needed between words, except while a result waits on the
// master side, the only case in which input ready drops; tlast marks the
// last vertex of a polygon and tuser the last polygon of a query (only
// together with tlast). The query point is read from the first word of each
// query. Each vertex word passes an input register, a product stage (four
// signed (COORD_BITS+1)-bit multipliers for the running edge and the closing
// edge) and a compare stage that updates the parity and registers the inside
// flag once the query's last vertex has left the product stage.
module point_in_polygon_crossing_top
    import pip_pkg::*;
#(
    parameter int unsigned COORD_BITS = CoordBitsDef
) (
    input  logic aclk,
    input  logic aresetn,
    // vertex_x, vertex_y, query_x, query_y (lowest bit up), zero padded
    input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic                                        s_tlast,
    // last_polygon
    input  logic                                        s_tuser,
    // inside_res, zero padded
    output logic [OutTdataW-1:0]                        m_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready
);

    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned PW = 2 * DW;

    // whole pipeline moves when the result register can take a word
    logic advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // input register
    logic                  in_valid_reg;
    logic [COORD_BITS-1:0] in_vx_reg, in_vy_reg, in_qx_reg, in_qy_reg;
    logic                  in_lastv_reg, in_lastp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
        if (advance) begin
            in_vx_reg    <= s_tdata[0 +: COORD_BITS];
            in_vy_reg    <= s_tdata[COORD_BITS +: COORD_BITS];
            in_qx_reg    <= s_tdata[2 * COORD_BITS +: COORD_BITS];
            in_qy_reg    <= s_tdata[3 * COORD_BITS +: COORD_BITS];
            in_lastv_reg <= s_tlast;
            in_lastp_reg <= s_tuser;
        end
    end

    // geometric state
    logic                  in_query_reg, in_polygon_reg;
    logic [COORD_BITS-1:0] point_x_reg, point_y_reg;
    logic [COORD_BITS-1:0] first_vx_reg, first_vy_reg, prev_vx_reg, prev_vy_reg;

    // point and first vertex as seen by the current word
    logic signed [DW-1:0] px, py, vx, vy, fx, fy, jx, jy;

    always_comb begin
        px = in_query_reg ? DW'($signed(point_x_reg)) : DW'($signed(in_qx_reg));
        py = in_query_reg ? DW'($signed(point_y_reg)) : DW'($signed(in_qy_reg));
        vx = DW'($signed(in_vx_reg));
        vy = DW'($signed(in_vy_reg));
        fx = in_polygon_reg ? DW'($signed(first_vx_reg)) : vx;
        fy = in_polygon_reg ? DW'($signed(first_vy_reg)) : vy;
        jx = DW'($signed(prev_vx_reg));
        jy = DW'($signed(prev_vy_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_query_reg   <= 1'b0;
            in_polygon_reg <= 1'b0;
        end else if (advance && in_valid_reg) begin
            in_polygon_reg <= !in_lastv_reg;
            in_query_reg   <= !(in_lastv_reg && in_lastp_reg);
        end
        if (advance && in_valid_reg) begin
            if (!in_query_reg) begin
                point_x_reg <= in_qx_reg;
                point_y_reg <= in_qy_reg;
            end
            if (!in_polygon_reg) begin
                first_vx_reg <= in_vx_reg;
                first_vy_reg <= in_vy_reg;
            end
            prev_vx_reg <= in_vx_reg;
            prev_vy_reg <= in_vy_reg;
        end
    end

    // edge a runs prev -> current, edge b closes current -> first
    logic signed [DW-1:0] da, db;
    logic                 str_a, str_b;

    always_comb begin
        da    = vy - jy;
        db    = fy - vy;
        str_a = (vy > py) != (jy > py);
        str_b = (fy > py) != (vy > py);
    end

    // product stage
    logic                 p_valid_reg;
    logic signed [PW-1:0] la_reg, ra_reg, lb_reg, rb_reg;
    logic                 dpos_a_reg, dpos_b_reg, str_a_reg, str_b_reg;
    logic                 new_poly_reg, new_query_reg, p_lastv_reg, p_lastp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (advance) begin
            p_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            la_reg        <= PW'(px - vx) * PW'(da);
            ra_reg        <= PW'(py - vy) * PW'(vx - jx);
            lb_reg        <= PW'(px - fx) * PW'(db);
            rb_reg        <= PW'(py - fy) * PW'(fx - vx);
            dpos_a_reg    <= da > 0;
            dpos_b_reg    <= db > 0;
            str_a_reg     <= str_a && in_polygon_reg;
            str_b_reg     <= str_b;
            new_poly_reg  <= !in_polygon_reg;
            new_query_reg <= !in_query_reg;
            p_lastv_reg   <= in_lastv_reg;
            p_lastp_reg   <= in_lastp_reg;
        end
    end

    // compare stage: parity and query result
    logic cross_a, cross_b;
    logic parity_reg, parity_next, any_reg, any_next;
    logic m_valid_reg, m_valid_next;
    logic inside_reg;

    always_comb begin
        cross_a = str_a_reg && (dpos_a_reg ? (la_reg < ra_reg) : (ra_reg < la_reg));
        cross_b = str_b_reg && (dpos_b_reg ? (lb_reg < rb_reg) : (rb_reg < lb_reg));
        parity_next = (new_poly_reg ? 1'b0 : parity_reg) ^ cross_a
                    ^ (p_lastv_reg && cross_b);
        any_next = new_query_reg ? 1'b0 : any_reg;
        if (p_lastv_reg) begin
            any_next = any_next || parity_next;
        end
        m_valid_next = p_valid_reg && p_lastv_reg && p_lastp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= m_valid_next;
        end
        if (advance && p_valid_reg) begin
            parity_reg <= parity_next;
            any_reg    <= any_next;
        end
        if (advance) begin
            inside_reg <= any_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OutTdataW - 1){1'b0}}, inside_reg};

`include "point_in_polygon_crossing_top_assert.svh"

    `PIP_ASSERT_IMP(a_last_word_gives_result, aclk, aresetn, advance && m_valid_next,
        m_tvalid, "query end produced no result")
    `PIP_ASSERT_IMP(a_tlast_closes_polygon, aclk, aresetn,
        advance && in_valid_reg && in_lastv_reg, !in_polygon_reg,
        "polygon not closed on last vertex")
    `PIP_ASSERT_IMP(a_query_end_rearms, aclk, aresetn,
        advance && in_valid_reg && in_lastv_reg && in_lastp_reg, !in_query_reg,
        "query not closed on last polygon")
    `PIP_ASSERT_AFTER_RESET(a_reset_clears_output, aclk, aresetn,
        !m_tvalid && !p_valid_reg && !in_valid_reg, "pipeline not empty after reset")

endmodule

FILE: dv/point_in_polygon_crossing_top_tb.sv
`timescale 1ns / 1ps

module point_in_polygon_crossing_top_tb;
    import pip_pkg::*;

    localparam int CoordW = CoordBitsDef;
    localparam int SDataW = ((4 * CoordW + 7) / 8) * 8;
    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles = 10;
    localparam int WordsPerPhase = 412;

    typedef logic signed [CoordW-1:0] coord_t;

    // one vertex word as it travels on the input stream
    typedef struct {
        coord_t vx;
        coord_t vy;
        coord_t qx;
        coord_t qy;
        logic   last_vertex;
        logic   last_polygon;
    } vertex_word_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    // vertex_x, vertex_y, query_x, query_y (lowest bit up), zero padded
    logic [SDataW-1:0]  s_tdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic               s_tlast = 1'b0;
    // last_polygon
    logic               s_tuser = 1'b0;
    // inside_res, zero padded
    logic [OutTdataW-1:0] m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    point_in_polygon_crossing_top #(
        .COORD_BITS(CoordW)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    vertex_word_t pending_words[$];
    logic         inside_q[$];
    vertex_word_t drv_word;
    logic         s_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           err_count = 0;
    int           idle_cycles = 0;
    int           n_words = 0;
    int           n_queries = 0;
    int           n_results = 0;
    int           n_inside = 0;

    // tracked state of the crossing test
    coord_t first_x = '0, first_y = '0, prev_x = '0, prev_y = '0;
    coord_t pnt_x = '0, pnt_y = '0;
    logic   mid_polygon = 1'b0, mid_query = 1'b0, par = 1'b0, hit = 1'b0;

    // edge from (jx,jy) to (ix,iy): straddles the point's y with the point left of it
    function automatic bit edge_flips(longint ix, longint iy, longint jx, longint jy,
                                      longint px, longint py);
        longint d;
        longint lhs;
        longint rhs;
        if ((iy > py) == (jy > py))
            return 1'b0;
        d = iy - jy;
        lhs = (px - ix) * d;
        rhs = (py - iy) * (ix - jx);
        if (d > 0)
            return lhs < rhs;
        return rhs < lhs;
    endfunction

    // advance the tracked state by one accepted word, queue the query verdict
    task automatic track_vertex(vertex_word_t w);
        if (!mid_query) begin
            pnt_x = w.qx;
            pnt_y = w.qy;
            hit = 1'b0;
            mid_query = 1'b1;
        end
        if (!mid_polygon) begin
            first_x = w.vx;
            first_y = w.vy;
            par = 1'b0;
            mid_polygon = 1'b1;
        end else if (edge_flips(w.vx, w.vy, prev_x, prev_y, pnt_x, pnt_y)) begin
            par = !par;
        end
        prev_x = w.vx;
        prev_y = w.vy;
        if (w.last_vertex) begin
            // closing edge back to the first vertex
            if (edge_flips(first_x, first_y, w.vx, w.vy, pnt_x, pnt_y))
                par = !par;
            hit = hit | par;
            mid_polygon = 1'b0;
            if (w.last_polygon) begin
                inside_q.push_back(hit);
                mid_query = 1'b0;
                n_results++;
                if (hit)
                    n_inside++;
            end
        end
    endtask

    function automatic coord_t clamp_coord(longint v);
        if (v > 32767)
            return coord_t'(32767);
        if (v < -32768)
            return coord_t'(-32768);
        return coord_t'(v);
    endfunction

    task automatic add_vertex(int vx, int vy, int qx, int qy, bit lv, bit lp);
        vertex_word_t w;
        w.vx = coord_t'(vx);
        w.vy = coord_t'(vy);
        w.qx = coord_t'(qx);
        w.qy = coord_t'(qy);
        w.last_vertex = lv;
        w.last_polygon = lp;
        pending_words.push_back(w);
        n_words++;
    endtask

    // one well-formed query with random polygons, mostly placed around the point
    task automatic gen_query(output int added);
        longint px, py, scale, ox, oy;
        int     npoly, nv, mode, q;
        bit     lv, lp;
        added = 0;
        if ($urandom_range(0, 3) == 0) begin
            px = longint'($urandom_range(0, 200)) - 100;
            py = longint'($urandom_range(0, 200)) - 100;
        end else begin
            px = longint'(coord_t'($urandom));
            py = longint'(coord_t'($urandom));
        end
        npoly = $urandom_range(1, 3);
        for (int p = 0; p < npoly; p++) begin
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            mode = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: scale = 16;
                1: scale = 300;
                2: scale = 6000;
                default: scale = 40000;
            endcase
            for (int k = 0; k < nv; k++) begin
                if (mode < 60) begin
                    // rotate through the quadrants so the point is often enclosed
                    q = ((k * 4 + 2) / nv) % 4;
                    ox = longint'($urandom_range(1, scale));
                    oy = longint'($urandom_range(1, scale));
                    if (q == 1 || q == 2)
                        ox = -ox;
                    if (q >= 2)
                        oy = -oy;
                    if ($urandom_range(0, 7) == 0)
                        oy = 0;
                    ox = px + ox;
                    oy = py + oy;
                end else if (mode < 85) begin
                    ox = px + longint'($urandom_range(0, 2 * scale)) - scale;
                    oy = py + longint'($urandom_range(0, 2 * scale)) - scale;
                end else begin
                    ox = longint'(coord_t'($urandom));
                    oy = longint'(coord_t'($urandom));
                end
                lv = (k == nv - 1);
                lp = lv && (p == npoly - 1);
                // stray last-polygon flag on an inner vertex
                if (!lv && $urandom_range(0, 9) == 0)
                    lp = 1'b1;
                // the query fields only count on the first word
                if (added == 0) begin
                    add_vertex(int'(clamp_coord(ox)), int'(clamp_coord(oy)),
                               int'(px), int'(py), lv, lp);
                end else begin
                    add_vertex(int'(clamp_coord(ox)), int'(clamp_coord(oy)),
                               int'($urandom), int'($urandom), lv, lp);
                end
                added++;
            end
        end
        n_queries++;
    endtask

    task automatic add_directed();
        // square around the origin
        add_vertex(-10, -10, 0, 0, 0, 0);
        add_vertex(10, -10, 1, 1, 0, 0);
        add_vertex(10, 10, 2, 2, 0, 0);
        add_vertex(-10, 10, 3, 3, 1, 1);
        // single-vertex polygon on the point itself
        add_vertex(5, 5, 5, 5, 1, 1);
        // two-vertex polygon straddling the point's y
        add_vertex(0, -5, -1, 0, 0, 0);
        add_vertex(0, 5, 0, 0, 1, 1);
        // triangle with a stray last-polygon flag on an inner vertex
        add_vertex(-20, -20, 0, 0, 0, 0);
        add_vertex(20, -20, 0, 0, 0, 1);
        add_vertex(0, 20, 0, 0, 1, 1);
        // full-range triangle with a horizontal base, point in the middle
        add_vertex(-32768, -32768, 0, 0, 0, 0);
        add_vertex(32767, -32768, -1, -1, 0, 0);
        add_vertex(0, 32767, -1, -1, 1, 1);
        // same triangle, point on the bottom-left corner
        add_vertex(-32768, -32768, -32768, -32768, 0, 0);
        add_vertex(32767, -32768, 32767, 32767, 0, 0);
        add_vertex(0, 32767, 32767, 32767, 1, 1);
        // same triangle, point at the top-right extreme
        add_vertex(-32768, -32768, 32767, 32767, 0, 0);
        add_vertex(32767, -32768, 0, 0, 0, 0);
        add_vertex(0, 32767, 0, 0, 1, 1);
        // two polygons: the first misses, the second holds the point
        add_vertex(100, 100, 3, 3, 0, 0);
        add_vertex(110, 100, 0, 0, 0, 0);
        add_vertex(105, 110, 0, 0, 1, 0);
        add_vertex(0, 0, 0, 0, 0, 0);
        add_vertex(6, 0, 0, 0, 0, 0);
        add_vertex(6, 6, 0, 0, 1, 1);
        n_queries += 8;
    endtask

    // wait until the input side is empty and every verdict has come back
    task automatic drain_all();
        while (pending_words.size() != 0 || s_tvalid || inside_q.size() != 0)
            @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    // input driver: changes at the falling edge
    always @(negedge aclk) begin
        vertex_word_t w;
        logic         nxt_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            if (!s_tvalid || s_taken) begin
                nxt_valid = 1'b0;
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    w = pending_words.pop_front();
                    drv_word <= w;
                    s_tdata <= SDataW'({w.qy, w.qx, w.vy, w.vx});
                    s_tlast <= w.last_vertex;
                    s_tuser <= w.last_polygon;
                    nxt_valid = 1'b1;
                end
            end
            s_tvalid <= nxt_valid;
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: samples at the rising edge, predicts and checks
    always @(posedge aclk) begin
        logic exp_inside;
        if (!aresetn) begin
            s_taken <= 1'b0;
            idle_cycles <= 0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                track_vertex(drv_word);
            if (m_tvalid && m_tready) begin
                if (inside_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result word %h", m_tdata);
                end else begin
                    exp_inside = inside_q.pop_front();
                    if (m_tdata !== OutTdataW'(exp_inside)) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("result mismatch: expected %h, got %h",
                                     OutTdataW'(exp_inside), m_tdata);
                    end
                end
            end
            // watchdog on cycles with no word moving either way
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WatchdogLimit) begin
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus sequence
    initial begin
        int added;
        int phase_words;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (ph == 0)
                add_directed();
            phase_words = 0;
            while (phase_words < WordsPerPhase) begin
                gen_query(added);
                phase_words += added;
            end
            // sender holds off here until every verdict is back
            drain_all();
        end
        $display("%0d vertex words in %0d queries, %0d verdicts checked (%0d inside)",
                 n_words, n_queries, n_results, n_inside);
        $display("idle mixes: none, sender gaps, receiver stalls, both; %0d mismatches",
                 err_count);
        if (err_count == 0 && inside_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pip_pkg.sv
rtl/point_in_polygon_crossing_top.sv
dv/point_in_polygon_crossing_top_tb.sv
